>>> hdl/ps2st_pkg.sv
// Shared types and constants for the PS/2 set-2 scancode translator.
// Used by ps2st_lookup, ps2st_state and ps2_scancode_translator_core. No dependencies.

package ps2st_pkg;

   localparam logic [7:0] CODE_RESET = 8'hFE;
   localparam logic [7:0] CODE_CAPS  = 8'h62;
   localparam logic [7:0] CODE_LCTRL = 8'h63;
   localparam logic [7:0] CODE_LGUI  = 8'h66;
   localparam logic [7:0] CODE_RGUI  = 8'h67;
   localparam logic [7:0] CODE_NONE  = 8'hFF;
   localparam logic [7:0] REL_BIT    = 8'h80;

   localparam logic [7:0] PREFIX_RELEASE  = 8'hF0;
   localparam logic [7:0] PREFIX_EXTENDED = 8'hE0;

   localparam logic [7:0] LCTRL_BITS = 8'hE0;
   localparam logic [7:0] LGUI_BITS  = 8'h1C;
   localparam logic [7:0] RGUI_BITS  = 8'h03;
   localparam logic [7:0] CHORD_FULL = 8'hFF;

   localparam logic [2:0] LED_CAPS = 3'd4;
   localparam logic [2:0] LED_OFF  = 3'd0;

   typedef enum logic [1:0] {
      KBD_NONE     = 2'd0,
      KBD_SET_LEDS = 2'd1,
      KBD_RESET    = 2'd2
   } kbd_cmd_type;

   typedef enum logic [2:0] {
      EV_PRESS      = 3'd0,
      EV_RELEASE    = 3'd1,
      EV_EXT_PRESS  = 3'd2,
      EV_EXT_RELEASE = 3'd3,
      EV_MALFORMED  = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     code;
   } lookup_type;

   typedef struct packed {
      logic [2:0]  led_value;
      kbd_cmd_type keyboard_command;
      logic        force_reset;
      logic [7:0]  target_code;
      logic        send_valid;
   } result_type;

endpackage

>>> hdl/ps2st_lookup.sv
// First stage: decodes the event kind and reads the normal and extended key ROMs.
// Depends on ps2st_pkg.

module ps2st_lookup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            prefix_count,
   input  logic [7:0]            first_prefix,
   input  logic [7:0]            key_code,
   input  logic                  advance,
   output logic                  lookup_valid,
   output ps2st_pkg::lookup_type lookup
);

   function automatic logic [7:0] rom_normal(input logic [7:0] k);
      logic [7:0] r;
      case (k)
         8'h01: r = 8'h58; 8'h03: r = 8'h54; 8'h04: r = 8'h52; 8'h05: r = 8'h50;
         8'h06: r = 8'h51; 8'h09: r = 8'h59; 8'h0A: r = 8'h57; 8'h0B: r = 8'h55;
         8'h0C: r = 8'h53; 8'h0D: r = 8'h42; 8'h0E: r = 8'h00; 8'h11: r = 8'h64;
         8'h12: r = 8'h60; 8'h14: r = 8'h63; 8'h15: r = 8'h10; 8'h16: r = 8'h01;
         8'h1A: r = 8'h31; 8'h1B: r = 8'h21; 8'h1C: r = 8'h20; 8'h1D: r = 8'h11;
         8'h1E: r = 8'h02; 8'h21: r = 8'h33; 8'h22: r = 8'h32; 8'h23: r = 8'h22;
         8'h24: r = 8'h12; 8'h25: r = 8'h04; 8'h26: r = 8'h03; 8'h29: r = 8'h40;
         8'h2A: r = 8'h34; 8'h2B: r = 8'h23; 8'h2C: r = 8'h14; 8'h2D: r = 8'h13;
         8'h2E: r = 8'h05; 8'h31: r = 8'h36; 8'h32: r = 8'h35; 8'h33: r = 8'h25;
         8'h34: r = 8'h24; 8'h35: r = 8'h15; 8'h36: r = 8'h06; 8'h3A: r = 8'h37;
         8'h3B: r = 8'h26; 8'h3C: r = 8'h16; 8'h3D: r = 8'h07; 8'h3E: r = 8'h08;
         8'h41: r = 8'h38; 8'h42: r = 8'h27; 8'h43: r = 8'h17; 8'h44: r = 8'h18;
         8'h45: r = 8'h0A; 8'h46: r = 8'h09; 8'h49: r = 8'h39; 8'h4A: r = 8'h3A;
         8'h4B: r = 8'h28; 8'h4C: r = 8'h29; 8'h4D: r = 8'h19; 8'h4E: r = 8'h0B;
         8'h52: r = 8'h2A; 8'h54: r = 8'h1A; 8'h55: r = 8'h0C; 8'h58: r = 8'h62;
         8'h59: r = 8'h61; 8'h5A: r = 8'h44; 8'h5B: r = 8'h1B; 8'h5D: r = 8'h0D;
         8'h66: r = 8'h41; 8'h69: r = 8'h1D; 8'h6B: r = 8'h2D; 8'h6C: r = 8'h3D;
         8'h70: r = 8'h0F; 8'h71: r = 8'h3C; 8'h72: r = 8'h1E; 8'h73: r = 8'h2E;
         8'h74: r = 8'h2F; 8'h75: r = 8'h3E; 8'h76: r = 8'h45; 8'h79: r = 8'h5E;
         8'h7A: r = 8'h1F; 8'h7B: r = 8'h4A; 8'h7C: r = 8'h5D; 8'h7D: r = 8'h3F;
         8'h83: r = 8'h56;
         default: r = ps2st_pkg::CODE_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rom_extended(input logic [7:0] k);
      logic [7:0] r;
      case (k)
         8'h11: r = 8'h65; 8'h14: r = 8'h63; 8'h1F: r = 8'h66; 8'h27: r = 8'h67;
         8'h4A: r = 8'h5C; 8'h5A: r = 8'h43; 8'h69: r = 8'hFE; 8'h6B: r = 8'h4F;
         8'h6C: r = 8'h5F; 8'h72: r = 8'h4D; 8'h74: r = 8'h4E; 8'h75: r = 8'h4C;
         default: r = ps2st_pkg::CODE_NONE;
      endcase
      return r;
   endfunction

   logic                      valid_ff, valid_in;
   logic                      load;
   ps2st_pkg::event_kind_type kind;
   ps2st_pkg::lookup_type     lookup_ff;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      unique case (prefix_count)
         2'd0: kind = ps2st_pkg::EV_PRESS;
         2'd1: begin
            if (first_prefix == ps2st_pkg::PREFIX_RELEASE) begin
               kind = ps2st_pkg::EV_RELEASE;
            end else if (first_prefix == ps2st_pkg::PREFIX_EXTENDED) begin
               kind = ps2st_pkg::EV_EXT_PRESS;
            end else begin
               kind = ps2st_pkg::EV_MALFORMED;
            end
         end
         2'd2: kind = ps2st_pkg::EV_EXT_RELEASE;
         default: kind = ps2st_pkg::EV_MALFORMED;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Synchronous ROM read; the selected table output is registered with the kind.
   always_ff @(posedge clock) begin
      if (load) begin
         lookup_ff.kind <= kind;
         case (kind)
            ps2st_pkg::EV_PRESS:       lookup_ff.code <= rom_normal(key_code);
            ps2st_pkg::EV_RELEASE:     lookup_ff.code <= rom_normal(key_code)
                                                         | ps2st_pkg::REL_BIT;
            ps2st_pkg::EV_EXT_PRESS:   lookup_ff.code <= rom_extended(key_code);
            ps2st_pkg::EV_EXT_RELEASE: lookup_ff.code <= rom_extended(key_code)
                                                         | ps2st_pkg::REL_BIT;
            default:                   lookup_ff.code <= ps2st_pkg::CODE_NONE;
         endcase
      end
   end

   assign lookup_valid = valid_ff;
   assign lookup       = lookup_ff;

endmodule

>>> hdl/ps2st_state.sv
// Second stage: chord mask, last code and caps latch update, and the result register.
// Depends on ps2st_pkg.

module ps2st_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  lookup_valid,
   input  ps2st_pkg::lookup_type lookup,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ps2st_pkg::result_type result
);

   logic                  fire;
   logic [7:0]            chord_ff, chord_in;
   logic [7:0]            last_ff, last_in;
   logic                  caps_ff, caps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            mask_upd;
   logic [7:0]            code;
   ps2st_pkg::result_type res_in;
   ps2st_pkg::result_type result_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = lookup_valid && advance;

   always_comb begin
      mask_upd = chord_ff;
      case (lookup.kind)
         ps2st_pkg::EV_PRESS: begin
            if (lookup.code == ps2st_pkg::CODE_LCTRL) begin
               mask_upd = chord_ff | ps2st_pkg::LCTRL_BITS;
            end
         end
         ps2st_pkg::EV_RELEASE: begin
            if (lookup.code == (ps2st_pkg::CODE_LCTRL | ps2st_pkg::REL_BIT)) begin
               mask_upd = chord_ff & ~ps2st_pkg::LCTRL_BITS;
            end
         end
         ps2st_pkg::EV_EXT_PRESS: begin
            if (lookup.code == ps2st_pkg::CODE_LGUI) begin
               mask_upd = chord_ff | ps2st_pkg::LGUI_BITS;
            end else if (lookup.code == ps2st_pkg::CODE_RGUI) begin
               mask_upd = chord_ff | ps2st_pkg::RGUI_BITS;
            end
         end
         ps2st_pkg::EV_EXT_RELEASE: begin
            if (lookup.code == (ps2st_pkg::CODE_LGUI | ps2st_pkg::REL_BIT)) begin
               mask_upd = chord_ff & ~ps2st_pkg::LGUI_BITS;
            end else if (lookup.code == (ps2st_pkg::CODE_RGUI | ps2st_pkg::REL_BIT)) begin
               mask_upd = chord_ff & ~ps2st_pkg::RGUI_BITS;
            end
         end
         default: mask_upd = chord_ff;
      endcase

      code = (mask_upd == ps2st_pkg::CHORD_FULL) ? ps2st_pkg::CODE_RESET : lookup.code;

      res_in   = '0;
      chord_in = mask_upd;
      caps_in  = caps_ff;
      last_in  = code;

      if (lookup.kind == ps2st_pkg::EV_MALFORMED) begin
         chord_in = chord_ff;
         last_in  = 8'h00;
      end else if (code == ps2st_pkg::CODE_RESET) begin
         chord_in                = 8'h00;
         caps_in                 = 1'b0;
         res_in.force_reset      = 1'b1;
         res_in.keyboard_command = ps2st_pkg::KBD_RESET;
      end else if (code != last_ff && code != ps2st_pkg::CODE_NONE) begin
         if (code == ps2st_pkg::CODE_CAPS) begin
            res_in.send_valid       = 1'b1;
            res_in.keyboard_command = ps2st_pkg::KBD_SET_LEDS;
            caps_in                 = !caps_ff;
            if (!caps_ff) begin
               res_in.target_code = ps2st_pkg::CODE_CAPS;
               res_in.led_value   = ps2st_pkg::LED_CAPS;
            end else begin
               res_in.target_code = ps2st_pkg::CODE_CAPS | ps2st_pkg::REL_BIT;
               res_in.led_value   = ps2st_pkg::LED_OFF;
            end
         end else if (code != (ps2st_pkg::CODE_CAPS | ps2st_pkg::REL_BIT)) begin
            res_in.send_valid  = 1'b1;
            res_in.target_code = code;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = lookup_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chord_ff     <= 8'h00;
         last_ff      <= ps2st_pkg::CODE_NONE;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            chord_ff <= chord_in;
            last_ff  <= last_in;
            caps_ff  <= caps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= res_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

>>> hdl/ps2_scancode_translator_core.sv
// Top level of the PS/2 set-2 scancode translator: ROM lookup stage and state stage.
// Depends on ps2st_pkg, ps2st_lookup and ps2st_state.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_tvalid/req_tready   prefix_count, first_prefix, key_code
//   rsp_      out        rsp_tvalid/rsp_tready   send_valid .. led_value
//
// The edge that accepts a request also registers the ROM read; the state update is then
// applied into the response register once it is empty or being taken, and rsp_tvalid
// rises with it. A new request is accepted every cycle while rsp_tready is high; the
// state registers are only in the second stage, so consecutive requests see each
// other's updates without stalls.
// Reset clears the chord mask and caps latch and sets the last code to 0xFF.
// When rsp_tready is low the pipeline holds and req_tready drops once both stages fill.

module ps2_scancode_translator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // prefix_count[1:0], first_prefix[9:2], key_code[17:10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // send_valid[0], target_code[8:1], force_reset[9],
                                   // keyboard_command[11:10], led_value[14:12]
);

   logic                  advance;
   logic                  lookup_valid;
   ps2st_pkg::lookup_type lookup;
   ps2st_pkg::result_type result;

   ps2st_lookup u_lookup (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .prefix_count (req_tdata[1:0]),
      .first_prefix (req_tdata[9:2]),
      .key_code     (req_tdata[17:10]),
      .advance      (advance),
      .lookup_valid (lookup_valid),
      .lookup       (lookup)
   );

   ps2st_state u_state (
      .clock        (clock),
      .reset        (reset),
      .lookup_valid (lookup_valid),
      .lookup       (lookup),
      .advance      (advance),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {1'b0, result};

endmodule

>>> test/ps2_scancode_translator_checker.sv
`timescale 1ns / 100ps
// Checker for ps2_scancode_translator_core: watches both stream channels, predicts each response.
// Depends on ps2st_pkg for the code constants, command enum and packed response layout.

module ps2_scancode_translator_checker
   import ps2st_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);

   logic [7:0] chord_bits;
   logic [7:0] prev_code;
   logic       caps_on;
   result_type pending_translations[$];

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   function automatic logic [7:0] set2_normal_map(input logic [7:0] key);
      case (key)
         8'h01: return 8'h58;  8'h03: return 8'h54;  8'h04: return 8'h52;
         8'h05: return 8'h50;  8'h06: return 8'h51;  8'h09: return 8'h59;
         8'h0A: return 8'h57;  8'h0B: return 8'h55;  8'h0C: return 8'h53;
         8'h0D: return 8'h42;  8'h0E: return 8'h00;  8'h11: return 8'h64;
         8'h12: return 8'h60;  8'h14: return 8'h63;  8'h15: return 8'h10;
         8'h16: return 8'h01;  8'h1A: return 8'h31;  8'h1B: return 8'h21;
         8'h1C: return 8'h20;  8'h1D: return 8'h11;  8'h1E: return 8'h02;
         8'h21: return 8'h33;  8'h22: return 8'h32;  8'h23: return 8'h22;
         8'h24: return 8'h12;  8'h25: return 8'h04;  8'h26: return 8'h03;
         8'h29: return 8'h40;  8'h2A: return 8'h34;  8'h2B: return 8'h23;
         8'h2C: return 8'h14;  8'h2D: return 8'h13;  8'h2E: return 8'h05;
         8'h31: return 8'h36;  8'h32: return 8'h35;  8'h33: return 8'h25;
         8'h34: return 8'h24;  8'h35: return 8'h15;  8'h36: return 8'h06;
         8'h3A: return 8'h37;  8'h3B: return 8'h26;  8'h3C: return 8'h16;
         8'h3D: return 8'h07;  8'h3E: return 8'h08;  8'h41: return 8'h38;
         8'h42: return 8'h27;  8'h43: return 8'h17;  8'h44: return 8'h18;
         8'h45: return 8'h0A;  8'h46: return 8'h09;  8'h49: return 8'h39;
         8'h4A: return 8'h3A;  8'h4B: return 8'h28;  8'h4C: return 8'h29;
         8'h4D: return 8'h19;  8'h4E: return 8'h0B;  8'h52: return 8'h2A;
         8'h54: return 8'h1A;  8'h55: return 8'h0C;  8'h58: return 8'h62;
         8'h59: return 8'h61;  8'h5A: return 8'h44;  8'h5B: return 8'h1B;
         8'h5D: return 8'h0D;  8'h66: return 8'h41;  8'h69: return 8'h1D;
         8'h6B: return 8'h2D;  8'h6C: return 8'h3D;  8'h70: return 8'h0F;
         8'h71: return 8'h3C;  8'h72: return 8'h1E;  8'h73: return 8'h2E;
         8'h74: return 8'h2F;  8'h75: return 8'h3E;  8'h76: return 8'h45;
         8'h79: return 8'h5E;  8'h7A: return 8'h1F;  8'h7B: return 8'h4A;
         8'h7C: return 8'h5D;  8'h7D: return 8'h3F;  8'h83: return 8'h56;
         default: return CODE_NONE;
      endcase
   endfunction

   function automatic logic [7:0] set2_extended_map(input logic [7:0] key);
      case (key)
         8'h11: return 8'h65;  8'h14: return 8'h63;  8'h1F: return 8'h66;
         8'h27: return 8'h67;  8'h4A: return 8'h5C;  8'h5A: return 8'h43;
         8'h69: return 8'hFE;  8'h6B: return 8'h4F;  8'h6C: return 8'h5F;
         8'h72: return 8'h4D;  8'h74: return 8'h4E;  8'h75: return 8'h4C;
         default: return CODE_NONE;
      endcase
   endfunction

   // Updates the chord mask, last code and caps latch and returns the response.
   function automatic result_type translate_event(input logic [1:0] count,
                                                  input logic [7:0] prefix,
                                                  input logic [7:0] key);
      result_type r;
      logic [7:0] code;
      r = '0;
      if (count == 2'd0) begin
         code = set2_normal_map(key);
         if (code == CODE_LCTRL) chord_bits |= LCTRL_BITS;
      end else if (count == 2'd1 && prefix == PREFIX_RELEASE) begin
         code = set2_normal_map(key) | REL_BIT;
         if (code == (CODE_LCTRL | REL_BIT)) chord_bits &= ~LCTRL_BITS;
      end else if (count == 2'd1 && prefix == PREFIX_EXTENDED) begin
         code = set2_extended_map(key);
         if (code == CODE_LGUI) chord_bits |= LGUI_BITS;
         else if (code == CODE_RGUI) chord_bits |= RGUI_BITS;
      end else if (count == 2'd2) begin
         code = set2_extended_map(key) | REL_BIT;
         if (code == (CODE_LGUI | REL_BIT)) chord_bits &= ~LGUI_BITS;
         else if (code == (CODE_RGUI | REL_BIT)) chord_bits &= ~RGUI_BITS;
      end else begin
         prev_code = 8'h00;
         return r;
      end

      if (chord_bits == CHORD_FULL) code = CODE_RESET;

      if (code == CODE_RESET) begin
         chord_bits = '0;
         caps_on = 1'b0;
         r.force_reset = 1'b1;
         r.keyboard_command = KBD_RESET;
      end else if (code != prev_code && code != CODE_NONE) begin
         if (code == CODE_CAPS) begin
            r.send_valid = 1'b1;
            r.keyboard_command = KBD_SET_LEDS;
            if (!caps_on) begin
               caps_on = 1'b1;
               r.target_code = CODE_CAPS;
               r.led_value = LED_CAPS;
            end else begin
               caps_on = 1'b0;
               r.target_code = CODE_CAPS | REL_BIT;
               r.led_value = LED_OFF;
            end
         end else if (code != (CODE_CAPS | REL_BIT)) begin
            r.send_valid = 1'b1;
            r.target_code = code;
         end
      end
      prev_code = code;
      return r;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: response field %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         chord_bits = '0;
         prev_code = CODE_NONE;
         caps_on = 1'b0;
         pending_translations.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[14:0]);
            if (pending_translations.size() == 0) begin
               error_count++;
               $display("%0t: response with nothing expected, expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_translations.pop_front();
               check_field("send_valid", want.send_valid, got.send_valid);
               check_field("target_code", want.target_code, got.target_code);
               check_field("force_reset", want.force_reset, got.force_reset);
               check_field("keyboard_command", want.keyboard_command,
                           got.keyboard_command);
               check_field("led_value", want.led_value, got.led_value);
            end
         end
         if (req_tvalid && req_tready)
            pending_translations.push_back(
               translate_event(req_tdata[1:0], req_tdata[9:2], req_tdata[17:10]));
      end
      pending_count = pending_translations.size();
   end

endmodule

>>> test/ps2_scancode_translator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for ps2_scancode_translator_core: drives key event requests and response stalls.
// Depends on ps2st_pkg, the core RTL and ps2_scancode_translator_checker.

module ps2_scancode_translator_core_tb;
   import ps2st_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   int          error_count;
   int          pending_count;

   int          send_idle = 0;
   int          recv_idle = 0;
   logic [7:0]  held_key = 8'h16;
   logic [7:0]  ext_keys [12] = '{8'h11, 8'h14, 8'h1F, 8'h27, 8'h4A, 8'h5A,
                                   8'h69, 8'h6B, 8'h6C, 8'h72, 8'h74, 8'h75};

   ps2_scancode_translator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ps2_scancode_translator_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #500000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_event(input logic [1:0] count, input logic [7:0] prefix,
                             input logic [7:0] key);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, key, prefix, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_events(input int total);
      int sent;
      int pick;
      int first;
      logic [1:0] count;
      logic [7:0] prefix;
      logic [7:0] key;
      sent = 0;
      count = 2'd0;
      prefix = 8'h00;
      key = 8'h16;
      while (sent < total) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            count = 2'd0;
            prefix = 8'($urandom_range(255));
            key = 8'($urandom_range(8'h83));
            held_key = key;
         end else if (pick < 62) begin
            count = 2'd1;
            prefix = PREFIX_RELEASE;
            key = ($urandom_range(3) == 0) ? 8'($urandom_range(8'h83)) : held_key;
         end else if (pick < 72) begin
            count = 2'd1;
            prefix = PREFIX_EXTENDED;
            key = ext_keys[$urandom_range(11)];
         end else if (pick < 80) begin
            count = 2'd2;
            prefix = ($urandom_range(1) == 0) ? PREFIX_EXTENDED : 8'($urandom_range(255));
            key = ext_keys[$urandom_range(11)];
         end else if (pick < 86) begin
            count = ($urandom_range(2) == 0) ? 2'd1 : 2'd0;
            prefix = PREFIX_RELEASE;
            key = 8'h58;
         end else if (pick < 91) begin
            // Chord keys in random order; some are released to leave the chord partial.
            first = $urandom_range(2);
            for (int i = 0; i < 3; i++) begin
               case ((first + i) % 3)
                  0: begin
                     count = ($urandom_range(4) == 0) ? 2'd1 : 2'd0;
                     prefix = PREFIX_RELEASE;
                     key = 8'h14;
                  end
                  1: begin
                     count = ($urandom_range(4) == 0) ? 2'd2 : 2'd1;
                     prefix = PREFIX_EXTENDED;
                     key = 8'h1F;
                  end
                  default: begin
                     count = ($urandom_range(4) == 0) ? 2'd2 : 2'd1;
                     prefix = PREFIX_EXTENDED;
                     key = 8'h27;
                  end
               endcase
               if (i < 2) begin
                  send_event(count, prefix, key);
                  sent++;
               end
            end
         end else if (pick < 95) begin
            // Repeat of the previous event.
         end else begin
            count = 2'($urandom_range(3));
            prefix = 8'($urandom_range(255));
            key = 8'($urandom_range(255));
         end
         send_event(count, prefix, key);
         sent++;
      end
   endtask

   initial begin : stimulus
      int wait_cycles;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle = 33;
      recv_idle = 71;
      send_event(2'd0, 8'h00, 8'h00);
      send_event(2'd0, 8'hFF, 8'hFF);
      send_event(2'd0, 8'h00, 8'h16);
      send_event(2'd0, 8'h00, 8'h16);
      send_event(2'd1, PREFIX_RELEASE, 8'h16);
      send_event(2'd1, 8'h00, 8'h16);
      send_event(2'd1, 8'hFF, 8'h00);
      send_event(2'd3, 8'hFF, 8'hFF);
      send_event(2'd0, 8'h00, 8'h58);
      send_event(2'd1, PREFIX_RELEASE, 8'h58);
      send_event(2'd0, 8'h00, 8'h58);
      send_event(2'd0, 8'h00, 8'h58);
      send_event(2'd1, PREFIX_EXTENDED, 8'h75);
      send_event(2'd2, 8'h00, 8'h75);
      send_event(2'd1, PREFIX_EXTENDED, 8'h69);
      send_event(2'd1, PREFIX_EXTENDED, 8'h69);
      send_event(2'd2, PREFIX_EXTENDED, 8'h69);
      send_event(2'd0, 8'h00, 8'h14);
      send_event(2'd1, PREFIX_EXTENDED, 8'h1F);
      send_event(2'd1, PREFIX_EXTENDED, 8'h27);
      send_event(2'd0, 8'h00, 8'h14);
      send_event(2'd1, PREFIX_RELEASE, 8'h14);
      send_event(2'd1, PREFIX_EXTENDED, 8'h1F);
      send_event(2'd2, PREFIX_EXTENDED, 8'h1F);
      send_event(2'd1, PREFIX_EXTENDED, 8'hFF);
      send_event(2'd0, 8'h00, 8'h83);
      send_random_events(450);

      send_idle = 71;
      recv_idle = 33;
      send_random_events(450);

      send_idle = 0;
      recv_idle = 0;
      send_random_events(450);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (10) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/ps2st_pkg.sv
hdl/ps2st_lookup.sv
hdl/ps2st_state.sv
hdl/ps2_scancode_translator_core.sv
test/ps2_scancode_translator_checker.sv
test/ps2_scancode_translator_core_tb.sv
